FILE: rtl/gdsu_pkg.sv
// ----------------------------------------------------------------------------
// gdsu_pkg
// shared types, constants, calendar helpers and the control program
// ----------------------------------------------------------------------------
package gdsu_pkg;

	// widths
	localparam int YEAR_W   = 18;         // exact working year, holds every result
	localparam int CNT_W    = 18;         // down counter, holds seven times the step count
	localparam int MOD_W    = 9;          // year mod 400
	localparam int PC_W     = 4;

	localparam logic [MOD_W-1:0] YEAR_CYCLE = 9'd400;

	// year mod 400 split as 25 * 16: low four bits pass, the rest is taken mod 25
	localparam int              SCALED_W    = YEAR_W - 4;
	localparam int              RECIP_W     = 13;
	localparam int              PROD_W      = SCALED_W + RECIP_W;
	localparam int              DIV_SHIFT   = 17;
	localparam int              QUOT_W      = PROD_W - DIV_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;   // 2^17 / 25 rounded up
	localparam logic [4:0]      CYCLE_DIV16 = 5'd25;

	// request codes
	localparam logic [2:0] REQ_ADD_DAY    = 3'd0;
	localparam logic [2:0] REQ_SUB_DAYS   = 3'd1;
	localparam logic [2:0] REQ_SUB_WEEKS  = 3'd2;
	localparam logic [2:0] REQ_SUB_MONTHS = 3'd3;
	localparam logic [2:0] REQ_SUB_YEARS  = 3'd4;

	// datapath actions
	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_MOD_START,
		DP_MOD_LOAD,
		DP_CLAMP,
		DP_ADD_DAY,
		DP_BACK_DAY,
		DP_BACK_MONTH,
		DP_SUB_YEAR,
		DP_FEB_FIX,
		DP_EMIT
	} dp_act_t;

	// jump conditions: jump to target when true, else fall through; dispatch jumps by request code
	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_IN_IDLE,
		JC_MOD_BUSY,
		JC_CNT_NZ,
		JC_OUT_BLOCKED,
		JC_DISPATCH
	} jump_cond_t;

	typedef struct packed {
		dp_act_t         act;
		jump_cond_t      jc;
		logic [PC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic       mod_busy;
		logic       cnt_nz;
		logic       out_blocked;
		logic [2:0] op;
	} dp_status_t;

	// program steps
	localparam logic [PC_W-1:0] STEP_IDLE       = 4'd0;
	localparam logic [PC_W-1:0] STEP_MOD_START  = 4'd1;
	localparam logic [PC_W-1:0] STEP_MOD_WAIT   = 4'd2;
	localparam logic [PC_W-1:0] STEP_MOD_LOAD   = 4'd3;
	localparam logic [PC_W-1:0] STEP_CLAMP      = 4'd4;
	localparam logic [PC_W-1:0] STEP_ADD_DAY    = 4'd5;
	localparam logic [PC_W-1:0] STEP_BACK_DAY   = 4'd6;
	localparam logic [PC_W-1:0] STEP_DAY_DONE   = 4'd7;
	localparam logic [PC_W-1:0] STEP_BACK_MON   = 4'd8;
	localparam logic [PC_W-1:0] STEP_MON_DONE   = 4'd9;
	localparam logic [PC_W-1:0] STEP_SUB_YEAR   = 4'd10;
	localparam logic [PC_W-1:0] STEP_YMOD_START = 4'd11;
	localparam logic [PC_W-1:0] STEP_YMOD_WAIT  = 4'd12;
	localparam logic [PC_W-1:0] STEP_YMOD_LOAD  = 4'd13;
	localparam logic [PC_W-1:0] STEP_FEB_FIX    = 4'd14;
	localparam logic [PC_W-1:0] STEP_EMIT       = 4'd15;

	// control store
	function automatic ucode_t ucode(logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{act: DP_NOP, jc: JC_NEXT, target: STEP_IDLE};
		unique case (pc)
			STEP_IDLE:       w = '{act: DP_LOAD,       jc: JC_IN_IDLE,     target: STEP_IDLE};
			STEP_MOD_START:  w = '{act: DP_MOD_START,  jc: JC_NEXT,        target: STEP_IDLE};
			STEP_MOD_WAIT:   w = '{act: DP_NOP,        jc: JC_MOD_BUSY,    target: STEP_MOD_WAIT};
			STEP_MOD_LOAD:   w = '{act: DP_MOD_LOAD,   jc: JC_NEXT,        target: STEP_IDLE};
			STEP_CLAMP:      w = '{act: DP_CLAMP,      jc: JC_DISPATCH,    target: STEP_IDLE};
			STEP_ADD_DAY:    w = '{act: DP_ADD_DAY,    jc: JC_ALWAYS,      target: STEP_EMIT};
			STEP_BACK_DAY:   w = '{act: DP_BACK_DAY,   jc: JC_CNT_NZ,      target: STEP_BACK_DAY};
			STEP_DAY_DONE:   w = '{act: DP_NOP,        jc: JC_ALWAYS,      target: STEP_EMIT};
			STEP_BACK_MON:   w = '{act: DP_BACK_MONTH, jc: JC_CNT_NZ,      target: STEP_BACK_MON};
			STEP_MON_DONE:   w = '{act: DP_NOP,        jc: JC_ALWAYS,      target: STEP_EMIT};
			STEP_SUB_YEAR:   w = '{act: DP_SUB_YEAR,   jc: JC_NEXT,        target: STEP_IDLE};
			STEP_YMOD_START: w = '{act: DP_MOD_START,  jc: JC_NEXT,        target: STEP_IDLE};
			STEP_YMOD_WAIT:  w = '{act: DP_NOP,        jc: JC_MOD_BUSY,    target: STEP_YMOD_WAIT};
			STEP_YMOD_LOAD:  w = '{act: DP_MOD_LOAD,   jc: JC_NEXT,        target: STEP_IDLE};
			STEP_FEB_FIX:    w = '{act: DP_FEB_FIX,    jc: JC_NEXT,        target: STEP_IDLE};
			STEP_EMIT:       w = '{act: DP_EMIT,       jc: JC_OUT_BLOCKED, target: STEP_EMIT};
			default:         w = '{act: DP_NOP,        jc: JC_ALWAYS,      target: STEP_IDLE};
		endcase
		return w;
	endfunction

	// first step of each request; unused codes go straight to the result
	function automatic logic [PC_W-1:0] dispatch(logic [2:0] op);
		logic [PC_W-1:0] t;
		t = STEP_EMIT;
		case (op) inside
			REQ_ADD_DAY:                 t = STEP_ADD_DAY;
			REQ_SUB_DAYS, REQ_SUB_WEEKS: t = STEP_BACK_DAY;
			REQ_SUB_MONTHS:              t = STEP_BACK_MON;
			REQ_SUB_YEARS:               t = STEP_SUB_YEAR;
			default:                     t = STEP_EMIT;
		endcase
		return t;
	endfunction

	// leap test from the year mod 400
	function automatic logic is_leap(logic [MOD_W-1:0] ymod);
		return (ymod[1:0] == 2'b00) &&
			!(ymod == 9'd100 || ymod == 9'd200 || ymod == 9'd300);
	endfunction

	function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
		logic [4:0] n;
		n = 5'd31;
		case (m) inside
			4'd2:                   n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			default:                n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/gdsu_mod400.sv
// ----------------------------------------------------------------------------
// gdsu_mod400
// remainder of a signed year by 400 through a reciprocal multiply
// ----------------------------------------------------------------------------
module gdsu_mod400 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [gdsu_pkg::YEAR_W-1:0]  value,
	output logic                                busy,
	output logic        [gdsu_pkg::MOD_W-1:0]   result
);
	import gdsu_pkg::*;

	logic                busy_q;
	logic                phase_q;
	logic [YEAR_W-1:0]   mag_q;
	logic [QUOT_W-1:0]   quot_q;
	logic [MOD_W-1:0]    rem_q;
	logic                neg_q;
	logic [SCALED_W-1:0] scaled;
	logic [PROD_W-1:0]   prod;
	logic [SCALED_W-1:0] back;
	logic [SCALED_W-1:0] diff;
	logic [MOD_W-1:0]    rem_next;

	// |y| mod 400 = ((|y| >> 4) mod 25) * 16 + (|y| mod 16)
	assign scaled   = mag_q[YEAR_W-1:4];
	assign prod     = PROD_W'(scaled) * PROD_W'(RECIP_25);
	assign back     = SCALED_W'(quot_q) * SCALED_W'(CYCLE_DIV16);
	assign diff     = scaled - back;
	assign rem_next = {diff[4:0], mag_q[3:0]};

	// busy phase 0 forms the quotient, phase 1 the remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			rem_q   <= '0;
			neg_q   <= 1'b0;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
			neg_q   <= value[YEAR_W-1];
		end else if (busy_q) begin
			if (!phase_q) begin
				phase_q <= 1'b1;
			end else begin
				busy_q <= 1'b0;
				rem_q  <= rem_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= value[YEAR_W-1] ? YEAR_W'(-value) : YEAR_W'(value);
		end else if (busy_q && !phase_q) begin
			quot_q <= prod[PROD_W-1:DIV_SHIFT];
		end
	end

	// floor remainder: negative years fold back into 0..399
	assign result = (neg_q && rem_q != '0) ? MOD_W'(YEAR_CYCLE - rem_q) : rem_q;
	assign busy   = busy_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("remainder unit not busy after start");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> result < YEAR_CYCLE)
		else $error("year remainder out of range");

endmodule

FILE: rtl/gdsu_datapath.sv
// ----------------------------------------------------------------------------
// gdsu_datapath
// date registers, down counter, year remainder tracking and result register
// ----------------------------------------------------------------------------
module gdsu_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gdsu_pkg::ucode_t           ctl,
	output gdsu_pkg::dp_status_t       status,
	input  logic                       in_valid,
	input  logic [2:0]                 req_type,
	input  logic signed [15:0]         in_year,
	input  logic [3:0]                 in_month,
	input  logic [4:0]                 in_day,
	input  logic [14:0]                step_count,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [15:0]         out_year,
	output logic [3:0]                 out_month,
	output logic [4:0]                 out_day,
	output logic                       year_out_of_range
);
	import gdsu_pkg::*;

	logic signed [YEAR_W-1:0] y_q;
	logic [3:0]               m_q;
	logic [4:0]               d_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [MOD_W-1:0]         ymod_q;
	logic [2:0]               op_q;

	logic                     out_valid_q;
	logic signed [15:0]       out_year_q;
	logic [3:0]               out_month_q;
	logic [4:0]               out_day_q;
	logic                     out_flag_q;

	logic                     mod_start;
	logic                     mod_busy;
	logic [MOD_W-1:0]         mod_result;
	logic                     leap;
	logic [4:0]               len_cur;
	logic [4:0]               len_prev;
	logic [3:0]               m_prev;
	logic [MOD_W-1:0]         ymod_dec;
	logic [MOD_W-1:0]         ymod_inc;
	logic                     cnt_nz;
	logic                     out_blocked;
	logic                     emit;
	logic                     wide_year;

	assign mod_start   = (ctl.act == DP_MOD_START);
	assign leap        = is_leap(ymod_q);
	assign len_cur     = month_days(m_q, leap);
	assign m_prev      = m_q - 4'd1;
	assign len_prev    = month_days(m_prev, leap);
	assign ymod_dec    = (ymod_q == '0) ? MOD_W'(YEAR_CYCLE - 9'd1) : ymod_q - 1'b1;
	assign ymod_inc    = (ymod_q == MOD_W'(YEAR_CYCLE - 9'd1)) ? '0 : ymod_q + 1'b1;
	assign cnt_nz      = (cnt_q != '0);
	assign out_blocked = out_valid_q && out_stall;
	assign emit        = (ctl.act == DP_EMIT) && !out_blocked;
	assign wide_year   = !(y_q[YEAR_W-1:15] == '0 || y_q[YEAR_W-1:15] == '1);

	gdsu_mod400 u_mod400 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (y_q),
		.busy   (mod_busy),
		.result (mod_result)
	);

	always_ff @(posedge clk) begin
		case (ctl.act)
			DP_LOAD: begin
				if (in_valid) begin
					op_q <= req_type;
					y_q  <= YEAR_W'(in_year);
					m_q  <= (in_month == 4'd0) ? 4'd1 : (in_month > 4'd12) ? 4'd12 : in_month;
					d_q  <= in_day;
					if (req_type == REQ_SUB_WEEKS) begin
						cnt_q <= {step_count, 3'b000} - {3'b000, step_count};
					end else begin
						cnt_q <= {3'b000, step_count};
					end
				end
			end
			DP_MOD_LOAD: ymod_q <= mod_result;
			DP_CLAMP: begin
				if (d_q == 5'd0) begin
					d_q <= 5'd1;
				end else if (d_q > len_cur) begin
					d_q <= len_cur;
				end
			end
			DP_ADD_DAY: begin
				if (d_q == len_cur) begin
					d_q <= 5'd1;
					if (m_q == 4'd12) begin
						m_q    <= 4'd1;
						y_q    <= y_q + YEAR_W'(1);
						ymod_q <= ymod_inc;
					end else begin
						m_q <= m_q + 4'd1;
					end
				end else begin
					d_q <= d_q + 5'd1;
				end
			end
			DP_BACK_DAY: begin
				if (cnt_nz) begin
					cnt_q <= cnt_q - 1'b1;
					if (d_q <= 5'd1) begin
						if (m_q <= 4'd1) begin
							y_q    <= y_q - YEAR_W'(1);
							ymod_q <= ymod_dec;
							m_q    <= 4'd12;
							d_q    <= 5'd31;
						end else begin
							m_q <= m_prev;
							d_q <= len_prev;
						end
					end else begin
						d_q <= d_q - 5'd1;
					end
				end
			end
			DP_BACK_MONTH: begin
				if (cnt_nz) begin
					cnt_q <= cnt_q - 1'b1;
					if (m_q == 4'd1) begin
						y_q    <= y_q - YEAR_W'(1);
						ymod_q <= ymod_dec;
						m_q    <= 4'd12;
					end else begin
						m_q <= m_prev;
						if (d_q > len_prev) begin
							d_q <= len_prev;
						end
					end
				end
			end
			DP_SUB_YEAR: y_q <= y_q - $signed({1'b0, cnt_q[CNT_W-2:0]});
			DP_FEB_FIX: begin
				if (m_q == 4'd2 && d_q == 5'd29 && !leap) begin
					d_q <= 5'd28;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_year_q  <= y_q[15:0];
			out_month_q <= m_q;
			out_day_q   <= d_q;
			out_flag_q  <= wide_year;
		end
	end

	assign status = '{mod_busy: mod_busy, cnt_nz: cnt_nz, out_blocked: out_blocked, op: op_q};

	assign out_valid         = out_valid_q;
	assign out_year          = out_year_q;
	assign out_month         = out_month_q;
	assign out_day           = out_day_q;
	assign year_out_of_range = out_flag_q;

	a_back_day_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.act == DP_BACK_DAY) && cnt_nz |=> d_q != 5'd0 && m_q != 4'd0 && m_q <= 4'd12)
		else $error("date left legal range while stepping back");

endmodule

FILE: rtl/gdsu_sequencer.sv
// ----------------------------------------------------------------------------
// gdsu_sequencer
// step counter over the control store with conditional jumps
// ----------------------------------------------------------------------------
module gdsu_sequencer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  gdsu_pkg::dp_status_t status,
	output gdsu_pkg::ucode_t     ctl
);
	import gdsu_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	ucode_t          word;
	logic            take;

	assign word = ucode(pc_q);

	always_comb begin
		take = 1'b0;
		unique case (word.jc)
			JC_NEXT:        take = 1'b0;
			JC_ALWAYS:      take = 1'b1;
			JC_IN_IDLE:     take = !in_valid;
			JC_MOD_BUSY:    take = status.mod_busy;
			JC_CNT_NZ:      take = status.cnt_nz;
			JC_OUT_BLOCKED: take = status.out_blocked;
			JC_DISPATCH:    take = 1'b1;
			default:        take = 1'b0;
		endcase
		if (word.jc == JC_DISPATCH) begin
			pc_next = dispatch(status.op);
		end else if (take) begin
			pc_next = word.target;
		end else begin
			pc_next = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	assign ctl      = word;
	assign in_stall = (pc_q != STEP_IDLE);

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> pc_q == STEP_MOD_START)
		else $error("accepted transaction did not start the program");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_EMIT) && status.out_blocked |=> pc_q == STEP_EMIT)
		else $error("result step left while output register full");

endmodule

FILE: rtl/gregorian_date_step_unit_top.sv
// ----------------------------------------------------------------------------
// gregorian_date_step_unit_top
// gregorian date step unit: add one day or subtract days, weeks, months, years
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. The block takes a date, a request
// code and a count, and returns the shifted date with a flag that marks a
// year outside the signed 16-bit range (the year then wraps). Items are
// worked one at a time under a small microprogram; a finished result sits in
// the output register, so the next transaction is taken while it waits.
// Setup after acceptance finds the year mod 400 with a reciprocal-multiply
// remainder unit, polled until it is done; then the request runs: adding one
// day is done directly, subtracting days, weeks or months loops once per unit
// (a week counts as seven days), subtracting years makes a second pass of the
// remainder unit, and an unused code goes straight to the result. The program
// is back in its idle step the cycle after the result is written; a result
// stalled in the output register holds the result step. The per-unit loops
// set the time an item takes for large counts.
// ----------------------------------------------------------------------------
module gregorian_date_step_unit_top (
	input  logic               clk,
	input  logic               arst_n,
	// request side
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic signed [15:0] in_year,
	input  logic [3:0]         in_month,
	input  logic [4:0]         in_day,
	input  logic [14:0]        step_count,
	// result side
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_year,
	output logic [3:0]         out_month,
	output logic [4:0]         out_day,
	output logic               year_out_of_range
);
	import gdsu_pkg::*;

	// control word from the program store, status back from the datapath
	ucode_t     ctl;
	dp_status_t status;

	// step counter and control store
	gdsu_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.ctl      (ctl)
	);

	// date registers, counter, leap tracking and result register
	gdsu_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.status            (status),
		.in_valid          (in_valid),
		.req_type          (req_type),
		.in_year           (in_year),
		.in_month          (in_month),
		.in_day            (in_day),
		.step_count        (step_count),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.out_year          (out_year),
		.out_month         (out_month),
		.out_day           (out_day),
		.year_out_of_range (year_out_of_range)
	);

endmodule

FILE: tb/gregorian_date_step_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_step_unit_checker
// watches both channels, predicts each shifted date and compares the results
// ----------------------------------------------------------------------------
module gregorian_date_step_unit_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic signed [15:0] in_year,
	input  logic [3:0]         in_month,
	input  logic [4:0]         in_day,
	input  logic [14:0]        step_count,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [15:0] out_year,
	input  logic [3:0]         out_month,
	input  logic [4:0]         out_day,
	input  logic               year_out_of_range,
	output int                 error_count,
	output int                 results_due
);
	import gdsu_pkg::*;

	typedef struct {
		logic signed [15:0] year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic               wrapped;
	} shifted_date_t;

	shifted_date_t date_q[$];

	function automatic bit is_leap_year(int y);
		return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
	endfunction

	function automatic int days_in(int y, int m);
		case (m)
			2: begin
				return is_leap_year(y) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				return 30;
			end
			default: begin
				return 31;
			end
		endcase
	endfunction

	function automatic shifted_date_t shift_date(logic [2:0] op, logic signed [15:0] yr,
		logic [3:0] mo, logic [4:0] dy, logic [14:0] cnt);
		int y;
		int m;
		int d;
		int n;
		int i;
		shifted_date_t r;
		y = yr;
		m = mo;
		d = dy;
		n = cnt;
		// out-of-range month and day are pulled to the nearest legal value
		if (m < 1) m = 1;
		if (m > 12) m = 12;
		if (d < 1) d = 1;
		if (d > days_in(y, m)) d = days_in(y, m);
		case (op)
			REQ_ADD_DAY: begin
				if (d == days_in(y, m)) begin
					d = 1;
					if (m == 12) begin
						m = 1;
						y++;
					end else begin
						m++;
					end
				end else begin
					d++;
				end
			end
			REQ_SUB_DAYS, REQ_SUB_WEEKS: begin
				if (op == REQ_SUB_WEEKS) n = n * 7;
				for (i = 0; i < n; i++) begin
					if (d > 1) begin
						d--;
					end else if (m > 1) begin
						m--;
						d = days_in(y, m);
					end else begin
						y--;
						m = 12;
						d = 31;
					end
				end
			end
			REQ_SUB_MONTHS: begin
				// the day clamp applies on every month passed, so it accumulates
				for (i = 0; i < n; i++) begin
					if (m == 1) begin
						y--;
						m = 12;
					end else begin
						m--;
						if (d > days_in(y, m)) d = days_in(y, m);
					end
				end
			end
			REQ_SUB_YEARS: begin
				y -= n;
				if (m == 2 && d == 29 && !is_leap_year(y)) d = 28;
			end
			default: begin
			end
		endcase
		r.year    = 16'(y);
		r.month   = 4'(m);
		r.day     = 5'(d);
		r.wrapped = (y < -32768) || (y > 32767);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		shifted_date_t want;
		if (!arst_n) begin
			date_q.delete();
			error_count = 0;
			results_due = 0;
		end else begin
			// results first: a result never belongs to a request taken at the same edge
			if (out_valid && !out_stall) begin
				if (date_q.size() == 0) begin
					$error("result with no request pending: year %0d month %0d day %0d",
						out_year, out_month, out_day);
					error_count++;
				end else begin
					want = date_q.pop_front();
					if (out_year !== want.year) begin
						$error("out_year: expected %0d, got %0d", want.year, out_year);
						error_count++;
					end
					if (out_month !== want.month) begin
						$error("out_month: expected %0d, got %0d", want.month, out_month);
						error_count++;
					end
					if (out_day !== want.day) begin
						$error("out_day: expected %0d, got %0d", want.day, out_day);
						error_count++;
					end
					if (year_out_of_range !== want.wrapped) begin
						$error("year_out_of_range: expected %0d, got %0d",
							want.wrapped, year_out_of_range);
						error_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				date_q.push_back(shift_date(req_type, in_year, in_month, in_day, step_count));
			end
			results_due = date_q.size();
		end
	end

endmodule

FILE: tb/gregorian_date_step_unit_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_step_unit_top_tb
// stimulus and verdict for the gregorian date step unit
// ----------------------------------------------------------------------------
// A directed set of dates exercises month and year ends, leap rules for
// positive and negative years, the 16-bit year wrap, maximum counts and the
// unused request codes. Random dates and counts follow, with random gaps on
// the request side and random stalls on the result side. A separate checker
// predicts every transaction and counts mismatches.
// ----------------------------------------------------------------------------
module gregorian_date_step_unit_top_tb;
	import gdsu_pkg::*;

	// request codes the block does not define; they return the date with month and day pulled into range
	localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
	localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

	localparam int RANDOM_ITEMS = 650;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         req_type;
	logic signed [15:0] in_year;
	logic [3:0]         in_month;
	logic [4:0]         in_day;
	logic [14:0]        step_count;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] out_year;
	logic [3:0]         out_month;
	logic [4:0]         out_day;
	logic               year_out_of_range;

	int                 error_count;
	int                 results_due;
	// while set, neither side idles
	logic               quiet;

	gregorian_date_step_unit_top DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.req_type          (req_type),
		.in_year           (in_year),
		.in_month          (in_month),
		.in_day            (in_day),
		.step_count        (step_count),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.out_year          (out_year),
		.out_month         (out_month),
		.out_day           (out_day),
		.year_out_of_range (year_out_of_range)
	);

	gregorian_date_step_unit_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.req_type          (req_type),
		.in_year           (in_year),
		.in_month          (in_month),
		.in_day            (in_day),
		.step_count        (step_count),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.out_year          (out_year),
		.out_month         (out_month),
		.out_day           (out_day),
		.year_out_of_range (year_out_of_range),
		.error_count       (error_count),
		.results_due       (results_due)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run, the 32767-week request included
	initial begin
		#40_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// idle length: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// one request transaction: optional idle, then hold until accepted
	task automatic send_request(input logic [2:0] op, input logic signed [15:0] yr,
		input logic [3:0] mo, input logic [4:0] dy, input logic [14:0] cnt);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid   = 1'b1;
		req_type   = op;
		in_year    = yr;
		in_month   = mo;
		in_day     = dy;
		step_count = cnt;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid and hold off until every expected result has come back
	task automatic idle_until_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (results_due != 0) @(negedge clk);
	endtask

	// result side: random stall bursts, none while quiet
	initial begin
		int   run_left;
		logic stall_next;
		out_stall = 1'b0;
		run_left  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (run_left > 0) begin
				run_left--;
			end else begin
				if (out_stall || quiet) begin
					stall_next = 1'b0;
					run_left   = $urandom_range(0, 12);
				end else begin
					run_left   = pick_gap();
					stall_next = (run_left != 0);
				end
				out_stall = stall_next;
			end
		end
	end

	// stimulus and verdict
	initial begin
		int               k;
		int               sel;
		int               yv;
		logic [2:0]       op;
		logic [3:0]       mo;
		logic [4:0]       dy;
		logic [14:0]      cnt;

		arst_n     = 1'b0;
		quiet      = 1'b0;
		in_valid   = 1'b0;
		req_type   = REQ_ADD_DAY;
		in_year    = '0;
		in_month   = 4'd1;
		in_day     = 5'd1;
		step_count = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// --- directed part ---
		// year end, leap february, common february
		send_request(REQ_ADD_DAY, 16'sd2023, 4'd12, 5'd31, 15'd0);
		send_request(REQ_ADD_DAY, 16'sd2024, 4'd2, 5'd28, 15'h7fff);
		send_request(REQ_ADD_DAY, 16'sd2023, 4'd2, 5'd28, 15'd5);
		// top of the year range wraps on new year's day
		send_request(REQ_ADD_DAY, 16'sd32767, 4'd12, 5'd31, 15'd0);
		// negative years: -100 common, -4, 0 and -400 leap
		send_request(REQ_ADD_DAY, -16'sd100, 4'd2, 5'd28, 15'd0);
		send_request(REQ_ADD_DAY, -16'sd4, 4'd2, 5'd28, 15'd0);
		send_request(REQ_ADD_DAY, 16'sd0, 4'd2, 5'd28, 15'd0);
		send_request(REQ_ADD_DAY, -16'sd400, 4'd2, 5'd28, 15'd0);
		// zero count and day past the month end
		send_request(REQ_SUB_DAYS, 16'sd2024, 4'd3, 5'd15, 15'd0);
		send_request(REQ_SUB_DAYS, 16'sd2023, 4'd2, 5'd31, 15'd0);
		// bottom of the year range (-32768) wraps going back one day
		send_request(REQ_SUB_DAYS, 16'sh8000, 4'd1, 5'd1, 15'd1);
		send_request(REQ_SUB_DAYS, 16'sd2024, 4'd6, 5'd15, 15'h7fff);
		send_request(REQ_SUB_WEEKS, 16'sd2024, 4'd3, 5'd5, 15'd1);
		// longest request the block takes
		send_request(REQ_SUB_WEEKS, 16'sd32767, 4'd12, 5'd31, 15'h7fff);
		// month steps: leap clamp, accumulated clamps, maximum count
		send_request(REQ_SUB_MONTHS, 16'sd2024, 4'd3, 5'd31, 15'd1);
		send_request(REQ_SUB_MONTHS, 16'sd2023, 4'd5, 5'd31, 15'd3);
		send_request(REQ_SUB_MONTHS, 16'sd1000, 4'd7, 5'd15, 15'h7fff);
		// year steps: 29 feb into a common year, leap to leap, wrap, zero count
		send_request(REQ_SUB_YEARS, 16'sd2024, 4'd2, 5'd29, 15'd1);
		send_request(REQ_SUB_YEARS, 16'sd2000, 4'd2, 5'd29, 15'd400);
		send_request(REQ_SUB_YEARS, 16'sh8000, 4'd6, 5'd10, 15'h7fff);
		send_request(REQ_SUB_YEARS, 16'sd2024, 4'd2, 5'd29, 15'd0);
		// unused codes, month and day outside their ranges
		send_request(REQ_UNUSED_LO, 16'sd1999, 4'd0, 5'd0, 15'h7fff);
		send_request(REQ_UNUSED_HI, -16'sd1, 4'd15, 5'd31, 15'd0);
		send_request(REQ_SUB_DAYS, 16'sd2021, 4'd13, 5'd0, 15'd3);
		idle_until_drained();

		// --- random part ---
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			// switch between idling and back-to-back stretches
			if (k % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
			// now and then let the block drain completely before going on
			if (k % 97 == 50) idle_until_drained();

			sel = $urandom_range(0, 99);
			if (sel < 6) op = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
			else op = 3'($urandom_range(REQ_ADD_DAY, REQ_SUB_YEARS));

			// years: anywhere, near either end of the range, or around the present and zero
			sel = $urandom_range(0, 9);
			if (sel < 3) yv = $urandom_range(0, 65535);
			else if (sel == 3) yv = -32768 + $urandom_range(0, 40);
			else if (sel == 4) yv = 32767 - $urandom_range(0, 40);
			else if (sel < 8) yv = $urandom_range(1500, 2500);
			else yv = $urandom_range(0, 1000) - 500;

			sel = $urandom_range(0, 99);
			if (sel < 90) begin
				mo = 4'($urandom_range(1, 12));
			end else begin
				sel = $urandom_range(0, 3);
				mo = (sel == 0) ? 4'd0 : 4'(12 + sel);
			end

			// bias toward month ends, where the carries and clamps happen
			sel = $urandom_range(0, 99);
			if (sel < 5) dy = 5'd0;
			else if (sel < 65) dy = 5'($urandom_range(1, 28));
			else dy = 5'($urandom_range(28, 31));

			// per-unit loops are slow, so day, week and month counts stay small
			sel = $urandom_range(0, 99);
			case (op)
				REQ_SUB_DAYS: begin
					cnt = (sel < 80) ? 15'($urandom_range(0, 60)) : 15'($urandom_range(0, 800));
				end
				REQ_SUB_WEEKS: begin
					cnt = (sel < 80) ? 15'($urandom_range(0, 20)) : 15'($urandom_range(0, 120));
				end
				REQ_SUB_MONTHS: begin
					cnt = (sel < 80) ? 15'($urandom_range(0, 40)) : 15'($urandom_range(0, 600));
				end
				REQ_SUB_YEARS: begin
					cnt = (sel < 70) ? 15'($urandom_range(0, 32767)) : 15'($urandom_range(0, 800));
				end
				default: begin
					cnt = 15'($urandom_range(0, 32767));
				end
			endcase

			send_request(op, 16'(yv), mo, dy, cnt);
		end

		// wind down: everything back, then a short tail for stray results
		quiet = 1'b0;
		idle_until_drained();
		repeat (100) @(negedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
